// ----- design/spcp_pkg.sv -----
// ----------------------------------------------------------------------------
// spcp_pkg: shared constants and types for the segment pair closest points
// Widths of the fixed-point datapath and the record carried down the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package spcp_pkg;

   // coordinate format, signed Q12.12 at the default width
   localparam int COORD_BITS = 24;

   // segment parameters, unsigned Q0.16 with one extra bit for the value one
   localparam int FRAC_BITS = 16;
   localparam int FRAC_W    = FRAC_BITS + 1;
   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

   // degenerate limit register
   localparam int LIMIT_BITS = 16;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1);

   // squared distance, saturating
   localparam int DIST_BITS = 51;
   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   // datapath widths
   localparam int DW   = COORD_BITS + 1;   // coordinate difference
   localparam int PW   = 2 * DW;           // product of two differences
   localparam int DOTW = PW + 1;           // dot product, signed
   localparam int MW   = PW;               // magnitude of a dot product
   localparam int HW   = MW / 2;           // half of a magnitude
   localparam int WW   = 2 * MW;           // product of two magnitudes
   localparam int RW   = WW + 2;           // ratio operands, signed

   // record that travels with every item down the pipe
   typedef struct packed {
      logic signed [COORD_BITS-1:0] a1x;
      logic signed [COORD_BITS-1:0] a1y;
      logic signed [COORD_BITS-1:0] a2x;
      logic signed [COORD_BITS-1:0] a2y;
      logic signed [DW-1:0]         d1x;
      logic signed [DW-1:0]         d1y;
      logic signed [DW-1:0]         d2x;
      logic signed [DW-1:0]         d2y;
      logic                         deg1;
      logic                         deg2;
      logic signed [DOTW-1:0]       len1;
      logic signed [DOTW-1:0]       len2;
      logic signed [DOTW-1:0]       r1;
      logic signed [DOTW-1:0]       r2;
      logic signed [DOTW-1:0]       b;
      logic                         den_nz;
      logic [FRAC_W-1:0]            s_main;
      logic [FRAC_W-1:0]            q_s0;
      logic [FRAC_W-1:0]            q_s1;
      logic [FRAC_W-1:0]            q_t0;
      logic                         tn_neg;
      logic                         tn_gt;
      logic [FRAC_W-1:0]            s_out;
      logic [FRAC_W-1:0]            t_out;
      logic signed [COORD_BITS-1:0] c1x;
      logic signed [COORD_BITS-1:0] c1y;
      logic signed [COORD_BITS-1:0] c2x;
      logic signed [COORD_BITS-1:0] c2y;
   } carry_type;

endpackage

`default_nettype wire

// ----- design/spcp_if.sv -----
// ----------------------------------------------------------------------------
// spcp channels: request and response handshake interfaces
// Valid/ready channels carrying one segment pair and one closest point result.
// ----------------------------------------------------------------------------
`default_nettype none

interface spcp_req_if;
   import spcp_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] first_start_x;
   logic signed [COORD_BITS-1:0] first_start_y;
   logic signed [COORD_BITS-1:0] first_end_x;
   logic signed [COORD_BITS-1:0] first_end_y;
   logic signed [COORD_BITS-1:0] second_start_x;
   logic signed [COORD_BITS-1:0] second_start_y;
   logic signed [COORD_BITS-1:0] second_end_x;
   logic signed [COORD_BITS-1:0] second_end_y;

   modport source (
      output valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      input  ready
   );

   modport sink (
      input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      output ready
   );
endinterface

interface spcp_rsp_if;
   import spcp_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [FRAC_W-1:0]            frac_first;
   logic [FRAC_W-1:0]            frac_second;
   logic signed [COORD_BITS-1:0] closest_first_x;
   logic signed [COORD_BITS-1:0] closest_first_y;
   logic signed [COORD_BITS-1:0] closest_second_x;
   logic signed [COORD_BITS-1:0] closest_second_y;
   logic [DIST_BITS-1:0]         distance_squared;

   modport source (
      output valid, frac_first, frac_second, closest_first_x, closest_first_y,
             closest_second_x, closest_second_y, distance_squared,
      input  ready
   );

   modport sink (
      input  valid, frac_first, frac_second, closest_first_x, closest_first_y,
             closest_second_x, closest_second_y, distance_squared,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/segment_pair_closest_points.sv -----
// ----------------------------------------------------------------------------
// segment_pair_closest_points: closest points between two 2D segments
//
// One transfer on req_ch carries the endpoints of two segments (Q12.12).
// One transfer on rsp_ch returns the clamped parameters s and t (Q0.16),
// the closest point on each segment and their squared distance (Q27.24).
// csr_we/csr_wdata write the degenerate length limit; write it while idle.
//
// Throughput: one pair per cycle while rsp_ch does not stall. The pipe holds
// two chains of 16 restoring divide steps, one register per quotient bit,
// the second fed by the s found by the first, plus the split wide
// multipliers and the point and distance stages around them.
// Reset clears all valid bits and sets the limit to one.
// When rsp_ch stalls the whole pipe holds, and req_ch.ready drops until the
// output register is taken; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_pair_closest_points (
   input  wire logic                            clock,
   input  wire logic                            reset,
   spcp_req_if.sink                             req_ch,
   spcp_rsp_if.source                           rsp_ch,
   input  wire logic                            csr_we,
   input  wire logic [spcp_pkg::LIMIT_BITS-1:0] csr_wdata
);
   import spcp_pkg::*;

   // stage positions along the pipe
   localparam int ST_DIFF  = 0;
   localparam int ST_PROD  = 1;
   localparam int ST_DOT   = 2;
   localparam int ST_PART  = 3;
   localparam int ST_WIDE  = 4;
   localparam int ST_DIV1  = 5;
   localparam int ST_X1    = ST_DIV1 + FRAC_BITS + 1;
   localparam int ST_X2    = ST_X1 + 1;
   localparam int ST_DIV2  = ST_X2 + 1;
   localparam int ST_SEL   = ST_DIV2 + FRAC_BITS + 1;
   localparam int ST_SCALE = ST_SEL + 1;
   localparam int ST_POINT = ST_SCALE + 1;
   localparam int ST_DELTA = ST_POINT + 1;
   localparam int ST_SQ    = ST_DELTA + 1;
   localparam int ST_OUT   = ST_SQ + 1;
   localparam int NSTAGE   = ST_OUT + 1;

   localparam int NLANE = 5;          // four ratios in the first set, one in the second
   localparam int NDEP  = FRAC_BITS + 1;
   localparam int BSW   = DOTW + FRAC_W + 1;
   localparam int SPW   = DW + FRAC_W + 1;
   localparam int DSW   = (DOTW > DIST_BITS) ? DOTW : DIST_BITS + 1;

   logic                   adv;
   logic [LIMIT_BITS-1:0]  limit_ff;
   logic                   v_ff [NSTAGE];
   carry_type              cr_ff [NSTAGE];
   carry_type              cr_in [NSTAGE];

   logic signed [DW-1:0]   rx_ff, ry_ff, rx_in, ry_in;
   logic signed [PW-1:0]   p_l1x_ff, p_l1y_ff, p_l2x_ff, p_l2y_ff;
   logic signed [PW-1:0]   p_r2x_ff, p_r2y_ff, p_r1x_ff, p_r1y_ff;
   logic signed [PW-1:0]   p_bx_ff, p_by_ff;
   logic [PW-1:0]          pp_ff [4][4];
   logic [PW-1:0]          pp_in [4][4];
   logic                   pneg_ff [4];
   logic                   pneg_in [4];
   logic signed [RW-1:0]   den_ff, sn_ff, den_in, sn_in;
   logic signed [BSW-1:0]  bs_ff, bs_in;
   logic signed [RW-1:0]   tn_ff, td_ff, tn_in, td_in;
   logic signed [SPW-1:0]  sp_ff [4];
   logic signed [SPW-1:0]  sp_in [4];
   logic signed [DW-1:0]   ex_ff, ey_ff, ex_in, ey_in;
   logic signed [PW-1:0]   sqx_ff, sqy_ff;
   logic [DIST_BITS-1:0]   dist_ff, dist_in;

   // divider lanes: entry operands and clamped quotients
   logic signed [RW-1:0]   num_w [NLANE];
   logic signed [RW-1:0]   dnm_w [NLANE];
   logic [FRAC_W-1:0]      q_w [NLANE];

   // whole pipe moves unless the output register holds an untaken result
   assign adv          = !v_ff[ST_OUT] || rsp_ch.ready;
   assign req_ch.ready = adv;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTAGE; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_ch.valid;
         for (int k = 1; k < NSTAGE; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   // record carried with each item, filled in as values appear
   always_comb begin
      cr_in[0]     = '0;
      cr_in[0].a1x = req_ch.first_start_x;
      cr_in[0].a1y = req_ch.first_start_y;
      cr_in[0].a2x = req_ch.second_start_x;
      cr_in[0].a2y = req_ch.second_start_y;
      cr_in[0].d1x = DW'(req_ch.first_end_x) - DW'(req_ch.first_start_x);
      cr_in[0].d1y = DW'(req_ch.first_end_y) - DW'(req_ch.first_start_y);
      cr_in[0].d2x = DW'(req_ch.second_end_x) - DW'(req_ch.second_start_x);
      cr_in[0].d2y = DW'(req_ch.second_end_y) - DW'(req_ch.second_start_y);
      for (int k = 1; k < NSTAGE; k++) cr_in[k] = cr_ff[k-1];

      // dot products and degenerate flags
      cr_in[ST_DOT].len1 = DOTW'(p_l1x_ff) + DOTW'(p_l1y_ff);
      cr_in[ST_DOT].len2 = DOTW'(p_l2x_ff) + DOTW'(p_l2y_ff);
      cr_in[ST_DOT].r2   = DOTW'(p_r2x_ff) + DOTW'(p_r2y_ff);
      cr_in[ST_DOT].r1   = DOTW'(p_r1x_ff) + DOTW'(p_r1y_ff);
      cr_in[ST_DOT].b    = DOTW'(p_bx_ff) + DOTW'(p_by_ff);
      cr_in[ST_DOT].deg1 = $unsigned(cr_in[ST_DOT].len1) <= DOTW'(limit_ff);
      cr_in[ST_DOT].deg2 = $unsigned(cr_in[ST_DOT].len2) <= DOTW'(limit_ff);

      // cross term zero means parallel
      cr_in[ST_DIV1].den_nz = (den_ff != '0);

      // first set of ratios done
      cr_in[ST_X1].s_main = cr_ff[ST_X1-1].den_nz ? q_w[0] : '0;
      cr_in[ST_X1].q_s0   = q_w[1];
      cr_in[ST_X1].q_s1   = q_w[2];
      cr_in[ST_X1].q_t0   = q_w[3];

      // range of unclamped t
      cr_in[ST_X2].tn_neg = tn_in[RW-1];
      cr_in[ST_X2].tn_gt  = tn_in > td_in;

      // final parameter choice
      begin
         carry_type c;
         c = cr_ff[ST_SEL-1];
         if (c.deg1 && c.deg2) begin
            cr_in[ST_SEL].s_out = '0;
            cr_in[ST_SEL].t_out = '0;
         end else if (c.deg1) begin
            cr_in[ST_SEL].s_out = '0;
            cr_in[ST_SEL].t_out = c.q_t0;
         end else if (c.deg2) begin
            cr_in[ST_SEL].s_out = c.q_s0;
            cr_in[ST_SEL].t_out = '0;
         end else if (c.tn_neg) begin
            cr_in[ST_SEL].s_out = c.q_s0;
            cr_in[ST_SEL].t_out = '0;
         end else if (c.tn_gt) begin
            cr_in[ST_SEL].s_out = c.q_s1;
            cr_in[ST_SEL].t_out = FRAC_ONE;
         end else begin
            cr_in[ST_SEL].s_out = c.s_main;
            cr_in[ST_SEL].t_out = q_w[NLANE-1];
         end
      end

      // closest points, offsets floor toward minus infinity
      begin
         logic signed [SPW-1:0] px1, py1, px2, py2;
         px1 = SPW'(cr_ff[ST_POINT-1].a1x) + (sp_ff[0] >>> FRAC_BITS);
         py1 = SPW'(cr_ff[ST_POINT-1].a1y) + (sp_ff[1] >>> FRAC_BITS);
         px2 = SPW'(cr_ff[ST_POINT-1].a2x) + (sp_ff[2] >>> FRAC_BITS);
         py2 = SPW'(cr_ff[ST_POINT-1].a2y) + (sp_ff[3] >>> FRAC_BITS);
         cr_in[ST_POINT].c1x = px1[COORD_BITS-1:0];
         cr_in[ST_POINT].c1y = py1[COORD_BITS-1:0];
         cr_in[ST_POINT].c2x = px2[COORD_BITS-1:0];
         cr_in[ST_POINT].c2y = py2[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NSTAGE; k++) cr_ff[k] <= cr_in[k];
      end
   end

   // offset between segment starts, and the short products
   assign rx_in = DW'(req_ch.first_start_x) - DW'(req_ch.second_start_x);
   assign ry_in = DW'(req_ch.first_start_y) - DW'(req_ch.second_start_y);

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff    <= rx_in;
         ry_ff    <= ry_in;
         p_l1x_ff <= cr_ff[ST_DIFF].d1x * cr_ff[ST_DIFF].d1x;
         p_l1y_ff <= cr_ff[ST_DIFF].d1y * cr_ff[ST_DIFF].d1y;
         p_l2x_ff <= cr_ff[ST_DIFF].d2x * cr_ff[ST_DIFF].d2x;
         p_l2y_ff <= cr_ff[ST_DIFF].d2y * cr_ff[ST_DIFF].d2y;
         p_r2x_ff <= cr_ff[ST_DIFF].d2x * rx_ff;
         p_r2y_ff <= cr_ff[ST_DIFF].d2y * ry_ff;
         p_r1x_ff <= cr_ff[ST_DIFF].d1x * rx_ff;
         p_r1y_ff <= cr_ff[ST_DIFF].d1y * ry_ff;
         p_bx_ff  <= cr_ff[ST_DIFF].d1x * cr_ff[ST_DIFF].d2x;
         p_by_ff  <= cr_ff[ST_DIFF].d1y * cr_ff[ST_DIFF].d2y;
      end
   end

   // wide products as four half-width partial products on magnitudes
   // order: len1*len2, b*b, b*r2, r1*len2
   always_comb begin
      logic signed [DOTW-1:0] opx [4];
      logic signed [DOTW-1:0] opy [4];
      logic [DOTW-1:0]        ax, ay;
      logic [MW-1:0]          mx, my;
      opx[0] = cr_ff[ST_PART-1].len1;  opy[0] = cr_ff[ST_PART-1].len2;
      opx[1] = cr_ff[ST_PART-1].b;     opy[1] = cr_ff[ST_PART-1].b;
      opx[2] = cr_ff[ST_PART-1].b;     opy[2] = cr_ff[ST_PART-1].r2;
      opx[3] = cr_ff[ST_PART-1].r1;    opy[3] = cr_ff[ST_PART-1].len2;
      for (int j = 0; j < 4; j++) begin
         ax = opx[j][DOTW-1] ? $unsigned(-opx[j]) : $unsigned(opx[j]);
         ay = opy[j][DOTW-1] ? $unsigned(-opy[j]) : $unsigned(opy[j]);
         mx = ax[MW-1:0];
         my = ay[MW-1:0];
         pneg_in[j]  = opx[j][DOTW-1] ^ opy[j][DOTW-1];
         pp_in[j][0] = PW'(mx[HW-1:0])  * PW'(my[HW-1:0]);
         pp_in[j][1] = PW'(mx[HW-1:0])  * PW'(my[MW-1:HW]);
         pp_in[j][2] = PW'(mx[MW-1:HW]) * PW'(my[HW-1:0]);
         pp_in[j][3] = PW'(mx[MW-1:HW]) * PW'(my[MW-1:HW]);
      end
   end

   // assemble partials, form cross term and numerator of s
   always_comb begin
      logic [WW-1:0]        sum;
      logic signed [RW-1:0] w [4];
      for (int j = 0; j < 4; j++) begin
         sum = (WW'(pp_ff[j][3]) << (2 * HW))
             + ((WW'(pp_ff[j][1]) + WW'(pp_ff[j][2])) << HW)
             + WW'(pp_ff[j][0]);
         w[j] = $signed({2'b00, sum});
         if (pneg_ff[j]) w[j] = -w[j];
      end
      den_in = w[0] - w[1];
      sn_in  = w[2] - w[3];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            pneg_ff[j] <= pneg_in[j];
            for (int h = 0; h < 4; h++) pp_ff[j][h] <= pp_in[j][h];
         end
         den_ff <= den_in;
         sn_ff  <= sn_in;
      end
   end

   // operands for the divider lanes
   always_comb begin
      num_w[0] = sn_ff;
      dnm_w[0] = den_ff;
      num_w[1] = -RW'(cr_ff[ST_WIDE].r1);
      dnm_w[1] = RW'(cr_ff[ST_WIDE].len1);
      num_w[2] = RW'(cr_ff[ST_WIDE].b) - RW'(cr_ff[ST_WIDE].r1);
      dnm_w[2] = RW'(cr_ff[ST_WIDE].len1);
      num_w[3] = RW'(cr_ff[ST_WIDE].r2);
      dnm_w[3] = RW'(cr_ff[ST_WIDE].len2);
      num_w[NLANE-1] = tn_ff;
      dnm_w[NLANE-1] = td_ff;
   end

   // restoring divide, one quotient bit per register stage
   for (genvar ln = 0; ln < NLANE; ln++) begin : g_lane
      logic [RW-1:0]        rem_ff [NDEP];
      logic [RW-1:0]        dnm_ff [NDEP];
      logic [FRAC_BITS-1:0] q_ff   [NDEP];
      logic                 zf_ff  [NDEP];
      logic                 of_ff  [NDEP];

      // clamp check on entry
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[0] <= $unsigned(num_w[ln]);
            dnm_ff[0] <= $unsigned(dnm_w[ln]);
            q_ff[0]   <= '0;
            zf_ff[0]  <= num_w[ln][RW-1] || (num_w[ln] == '0);
            of_ff[0]  <= !(num_w[ln][RW-1] || (num_w[ln] == '0))
                         && (num_w[ln] >= dnm_w[ln]);
         end
      end

      for (genvar st = 1; st < NDEP; st++) begin : g_step
         logic [RW-1:0] sh;
         logic          ge;
         assign sh = {rem_ff[st-1][RW-2:0], 1'b0};
         assign ge = sh >= dnm_ff[st-1];

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[st] <= ge ? sh - dnm_ff[st-1] : sh;
               dnm_ff[st] <= dnm_ff[st-1];
               q_ff[st]   <= {q_ff[st-1][FRAC_BITS-2:0], ge};
               zf_ff[st]  <= zf_ff[st-1];
               of_ff[st]  <= of_ff[st-1];
            end
         end
      end

      assign q_w[ln] = of_ff[NDEP-1] ? FRAC_ONE :
                       zf_ff[NDEP-1] ? '0 : {1'b0, q_ff[NDEP-1]};
   end

   // t numerator from the quantized s
   assign bs_in = $signed(cr_ff[ST_X1-1].b)
                * $signed({1'b0, (cr_ff[ST_X1-1].den_nz ? q_w[0] : FRAC_W'(0))});
   assign tn_in = RW'(bs_ff) + (RW'(cr_ff[ST_X2-1].r2) <<< FRAC_BITS);
   assign td_in = RW'(cr_ff[ST_X2-1].len2) <<< FRAC_BITS;

   always_ff @(posedge clock) begin
      if (adv) begin
         bs_ff <= bs_in;
         tn_ff <= tn_in;
         td_ff <= td_in;
      end
   end

   // direction times parameter
   always_comb begin
      logic signed [FRAC_W:0] sq, tq;
      sq = $signed({1'b0, cr_ff[ST_SCALE-1].s_out});
      tq = $signed({1'b0, cr_ff[ST_SCALE-1].t_out});
      sp_in[0] = cr_ff[ST_SCALE-1].d1x * sq;
      sp_in[1] = cr_ff[ST_SCALE-1].d1y * sq;
      sp_in[2] = cr_ff[ST_SCALE-1].d2x * tq;
      sp_in[3] = cr_ff[ST_SCALE-1].d2y * tq;
   end

   // gap between closest points and its square
   assign ex_in = DW'(cr_ff[ST_DELTA-1].c1x) - DW'(cr_ff[ST_DELTA-1].c2x);
   assign ey_in = DW'(cr_ff[ST_DELTA-1].c1y) - DW'(cr_ff[ST_DELTA-1].c2y);

   // squared distance with saturation
   always_comb begin
      logic signed [DOTW-1:0] sum;
      logic [DSW-1:0]         ds;
      sum = DOTW'(sqx_ff) + DOTW'(sqy_ff);
      ds  = DSW'($unsigned(sum));
      if (ds > DSW'(DIST_MAX)) dist_in = DIST_MAX;
      else                     dist_in = ds[DIST_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) sp_ff[j] <= sp_in[j];
         ex_ff   <= ex_in;
         ey_ff   <= ey_in;
         sqx_ff  <= ex_ff * ex_ff;
         sqy_ff  <= ey_ff * ey_ff;
         dist_ff <= dist_in;
      end
   end

   // response
   assign rsp_ch.valid            = v_ff[ST_OUT];
   assign rsp_ch.frac_first       = cr_ff[ST_OUT].s_out;
   assign rsp_ch.frac_second      = cr_ff[ST_OUT].t_out;
   assign rsp_ch.closest_first_x  = cr_ff[ST_OUT].c1x;
   assign rsp_ch.closest_first_y  = cr_ff[ST_OUT].c1y;
   assign rsp_ch.closest_second_x = cr_ff[ST_OUT].c2x;
   assign rsp_ch.closest_second_y = cr_ff[ST_OUT].c2y;
   assign rsp_ch.distance_squared = dist_ff;

   // checks
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.frac_first <= FRAC_ONE && rsp_ch.frac_second <= FRAC_ONE))
      else $error("closest point parameter above one");

   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready == (!rsp_ch.valid || rsp_ch.ready))
      else $error("request ready does not track output register");

   a_last_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (adv && v_ff[ST_SQ]) |=> rsp_ch.valid)
      else $error("item lost before output register");

   a_transfer_in_moves: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> v_ff[ST_DIFF])
      else $error("accepted pair not captured");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for segment_pair_closest_points
// Drives segment pairs through the request channel and checks each result
// against a table value or an in-bench fixed-point predictor. A short directed
// table comes first, then random pairs under several limits and stall patterns.
// ----------------------------------------------------------------------------

module tb_top;
   import spcp_pkg::*;

   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  DRAIN_WAIT  = 60;     // covers the pipe depth
   localparam int  PHASE_ITEMS = 200;
   localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};

   typedef logic signed [191:0] wide_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a1x, a1y, b1x, b1y, a2x, a2y, b2x, b2y;
   } pair_type;

   typedef struct packed {
      logic [FRAC_W-1:0]            s;
      logic [FRAC_W-1:0]            t;
      logic signed [COORD_BITS-1:0] c1x, c1y, c2x, c2y;
      logic [DIST_BITS-1:0]         gap_sq;
   } closest_type;

   typedef struct packed {
      pair_type    p;
      logic        known;
      closest_type r;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [LIMIT_BITS-1:0] csr_wdata = '0;

   spcp_req_if req_ch ();
   spcp_rsp_if rsp_ch ();

   segment_pair_closest_points DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // mirrored limit register and the queue of pending closest point results
   logic [LIMIT_BITS-1:0] limit_q = LIMIT_RESET;
   closest_type pending_q[$];
   int  mismatches = 0;
   int  cycles = 0;
   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   int  hold_off = 0;

   always #4 clock = ~clock;

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.first_start_x  = '0;
      req_ch.first_start_y  = '0;
      req_ch.first_end_x    = '0;
      req_ch.first_end_y    = '0;
      req_ch.second_start_x = '0;
      req_ch.second_start_y = '0;
      req_ch.second_end_x   = '0;
      req_ch.second_end_y   = '0;
      rsp_ch.ready          = 1'b0;
   end

   // clamped ratio n/d in Q0.16, truncating
   function automatic logic [FRAC_W-1:0] clamp_ratio(wide_type n, wide_type d);
      wide_type rem;
      logic [FRAC_W-1:0] q;
      if (n <= 0) return '0;
      if (n >= d) return FRAC_ONE;
      rem = n;
      q = '0;
      for (int i = 0; i < FRAC_BITS; i++) begin
         rem = rem <<< 1;
         q = q << 1;
         if (rem >= d) begin
            rem = rem - d;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // closest points, parameters and squared distance for one segment pair
   function automatic closest_type closest_points(pair_type p, logic [LIMIT_BITS-1:0] lim);
      longint d1x, d1y, d2x, d2y, rx, ry, ex, ey, sv, tv, c1x, c1y, c2x, c2y, dsq;
      wide_type len1, len2, r1, r2, b, den, tn, td;
      logic deg1, deg2;
      closest_type r;
      d1x = longint'(p.b1x) - p.a1x;
      d1y = longint'(p.b1y) - p.a1y;
      d2x = longint'(p.b2x) - p.a2x;
      d2y = longint'(p.b2y) - p.a2y;
      rx  = longint'(p.a1x) - p.a2x;
      ry  = longint'(p.a1y) - p.a2y;
      len1 = wide_type'(d1x) * wide_type'(d1x) + wide_type'(d1y) * wide_type'(d1y);
      len2 = wide_type'(d2x) * wide_type'(d2x) + wide_type'(d2y) * wide_type'(d2y);
      r1   = wide_type'(d1x) * wide_type'(rx) + wide_type'(d1y) * wide_type'(ry);
      r2   = wide_type'(d2x) * wide_type'(rx) + wide_type'(d2y) * wide_type'(ry);
      b    = wide_type'(d1x) * wide_type'(d2x) + wide_type'(d1y) * wide_type'(d2y);
      deg1 = len1 <= wide_type'(longint'(lim));
      deg2 = len2 <= wide_type'(longint'(lim));
      sv = 0;
      tv = 0;
      if (deg1 && deg2) begin
         sv = 0;
      end else if (deg1) begin
         tv = clamp_ratio(r2, len2);
      end else if (deg2) begin
         sv = clamp_ratio(-r1, len1);
      end else begin
         // general case, t from the quantized s, s redone when t clamps
         den = len1 * len2 - b * b;
         sv = (den != 0) ? longint'(clamp_ratio(b * r2 - r1 * len2, den)) : 0;
         tn = b * wide_type'(sv) + r2 * wide_type'(65536);
         td = len2 * wide_type'(65536);
         if (tn < 0) begin
            tv = 0;
            sv = clamp_ratio(-r1, len1);
         end else if (tn > td) begin
            tv = FRAC_ONE;
            sv = clamp_ratio(b - r1, len1);
         end else begin
            tv = clamp_ratio(tn, td);
         end
      end
      c1x = p.a1x + ((d1x * sv) >>> 16);
      c1y = p.a1y + ((d1y * sv) >>> 16);
      c2x = p.a2x + ((d2x * tv) >>> 16);
      c2y = p.a2y + ((d2y * tv) >>> 16);
      ex = c1x - c2x;
      ey = c1y - c2y;
      dsq = ex * ex + ey * ey;
      r.s      = FRAC_W'(sv);
      r.t      = FRAC_W'(tv);
      r.c1x    = COORD_BITS'(c1x);
      r.c1y    = COORD_BITS'(c1y);
      r.c2x    = COORD_BITS'(c2x);
      r.c2y    = COORD_BITS'(c2y);
      r.gap_sq = (dsq > longint'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(dsq);
      return r;
   endfunction

   // one coordinate near a base, clamped to the coordinate range
   function automatic logic signed [COORD_BITS-1:0] near(longint base, int span);
      longint v;
      v = base + $signed($urandom_range(2 * span)) - span;
      if (v > CMAX) v = CMAX;
      if (v < CMIN) v = CMIN;
      return COORD_BITS'(v);
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int kind;
      int k;
      kind = $urandom_range(5);
      p = pair_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      case (kind)
         1: begin
            p.a1x = near(0, 20000); p.a1y = near(0, 20000);
            p.b1x = near(0, 20000); p.b1y = near(0, 20000);
            p.a2x = near(0, 20000); p.a2y = near(0, 20000);
            p.b2x = near(0, 20000); p.b2y = near(0, 20000);
         end
         2: begin
            // short segments around the degenerate limit
            p.b1x = near(p.a1x, 200); p.b1y = near(p.a1y, 200);
            if ($urandom_range(1)) begin
               p.b2x = near(p.a2x, 200); p.b2y = near(p.a2y, 200);
            end
         end
         3: begin
            // parallel segments, second direction a multiple of the first
            p.a1x = near(0, 100000); p.a1y = near(0, 100000);
            p.b1x = near(p.a1x, 30000); p.b1y = near(p.a1y, 30000);
            p.a2x = near(0, 100000); p.a2y = near(0, 100000);
            k = $signed($urandom_range(6)) - 3;
            p.b2x = near(p.a2x + k * (longint'(p.b1x) - p.a1x), 0);
            p.b2y = near(p.a2y + k * (longint'(p.b1y) - p.a1y), 0);
         end
         4: begin
            if ($urandom_range(1)) begin
               p.b1x = p.a1x; p.b1y = p.a1y;
            end else begin
               p.a2x = p.b1x; p.a2y = p.b1y;
            end
         end
         5: begin
            p.a1x = $urandom_range(1) ? CMIN : CMAX;
            p.b2y = $urandom_range(1) ? CMIN : CMAX;
            p.b1y = $urandom_range(1) ? CMIN : CMAX;
         end
         default: ;
      endcase
      return p;
   endfunction

   // offer one pair and wait for its transfer
   task automatic send_pair(pair_type p, logic known, closest_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.first_start_x  <= p.a1x;
      req_ch.first_start_y  <= p.a1y;
      req_ch.first_end_x    <= p.b1x;
      req_ch.first_end_y    <= p.b1y;
      req_ch.second_start_x <= p.a2x;
      req_ch.second_start_y <= p.a2y;
      req_ch.second_end_x   <= p.b2x;
      req_ch.second_end_y   <= p.b2y;
      do @(posedge clock); while (!req_ch.ready);
      pending_q.push_back(known ? r : closest_points(p, limit_q));
   endtask

   // quiet the request side, drain, then let the pipe settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_BITS-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      limit_q    = v;
      @(posedge clock);
   endtask

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // compare each result transfer with the oldest pending result
   always @(posedge clock) begin
      closest_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.frac_first, rsp_ch.frac_second, rsp_ch.closest_first_x,
                 rsp_ch.closest_first_y, rsp_ch.closest_second_x,
                 rsp_ch.closest_second_y, rsp_ch.distance_squared};
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %p", got);
         end else begin
            want = pending_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result differs: expected %p actual %p", want, got);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("segment_pair_closest_points: mismatch");
         $finish;
      end
   end

   initial begin
      row_type rows[];
      logic [LIMIT_BITS-1:0] limits[4];
      int idle_tx[3];
      int idle_rx[3];
      rows = '{
         '{'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, 1'b1,
           '{17'd0, 17'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 51'd0}},
         '{'{CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX}, 1'b1,
           '{17'd0, 17'd0, CMIN, CMIN, CMAX, CMAX, 51'd562949886312450}},
         // parallel, offset by one unit
         '{'{24'sd0, 24'sd0, 24'sd4096, 24'sd0, 24'sd0, 24'sd4096, 24'sd4096, 24'sd4096},
           1'b1, '{17'd0, 17'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd4096, 51'd16777216}},
         // crossing
         '{'{-24'sd4096, -24'sd4096, 24'sd4096, 24'sd4096,
             -24'sd4096, 24'sd4096, 24'sd4096, -24'sd4096}, 1'b0, '0},
         // t below zero
         '{'{24'sd0, 24'sd0, 24'sd8192, 24'sd0,
             -24'sd8192, 24'sd4096, -24'sd16384, 24'sd8192}, 1'b0, '0},
         '{'{24'sd0, 24'sd0, 24'sd8192, 24'sd0,
             24'sd4096, 24'sd4096, 24'sd4096, 24'sd12288}, 1'b0, '0},
         // first segment a point, then second
         '{'{24'sd100, 24'sd100, 24'sd100, 24'sd100,
             24'sd0, 24'sd0, 24'sd8192, 24'sd8192}, 1'b0, '0},
         '{'{24'sd0, 24'sd0, 24'sd8192, 24'sd0,
             24'sd4096, -24'sd4096, 24'sd4096, -24'sd4096}, 1'b0, '0},
         // longest segments
         '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0, '0},
         '{'{CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN}, 1'b0, '0},
         '{'{CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN}, 1'b0, '0},
         // collinear overlap
         '{'{24'sd0, 24'sd0, 24'sd8192, 24'sd0,
             24'sd4096, 24'sd0, 24'sd12288, 24'sd0}, 1'b0, '0},
         // length exactly at the limit, then just above
         '{'{24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd5, 24'sd5, 24'sd5000, 24'sd5},
           1'b0, '0},
         '{'{24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd5, 24'sd5, 24'sd5000, 24'sd5},
           1'b0, '0},
         // s near one, and touching endpoints
         '{'{24'sd0, 24'sd0, 24'sd8192, 24'sd0,
             24'sd8192, 24'sd100, 24'sd8192, 24'sd9000}, 1'b0, '0},
         '{'{24'sd0, 24'sd0, 24'sd4096, 24'sd0,
             24'sd4096, 24'sd0, 24'sd4096, 24'sd4096}, 1'b0, '0}
      };
      limits  = '{16'd0, 16'd65535, 16'd0, 16'd1};
      idle_tx = '{38, 69, 0};
      idle_rx = '{69, 38, 0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under the reset limit
      foreach (rows[i]) send_pair(rows[i].p, rows[i].known, rows[i].r);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_limit(ph == 2 ? LIMIT_BITS'($urandom_range(65535)) : limits[ph]);
         for (int m = 0; m < 3; m++) begin
            tx_idle_pct = idle_tx[m];
            rx_idle_pct = idle_rx[m];
            // long receiver hold-off while the sender keeps offering
            if (ph == 1 && m == 2) hold_off = 400;
            for (int n = 0; n < PHASE_ITEMS / 3; n++) send_pair(random_pair(), 1'b0, '0);
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("segment_pair_closest_points: match");
      end else begin
         $display("segment_pair_closest_points: mismatch");
      end
      $finish;
   end

endmodule
